/* hdl/i2cew_pkg.sv */
// ----------------------------------------------------------------------------
// i2cew_pkg: shared types and constants
// Word formats, bus sequencer phases and register indexes for the I2C EEPROM
// word transfer block.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cew_pkg;

  // Bytes moved per transfer (1..4, the data word is 32 bits)
  localparam int unsigned BYTES_PER_TRANSFER = 4;

  // Byte counter holds up to control, two address bytes, repeated control
  // and the data bytes
  localparam int unsigned BYTE_W = $clog2(BYTES_PER_TRANSFER + 5);
  localparam int unsigned BIT_W  = 4;
  localparam int unsigned TICK_W = 24;

  localparam logic [BYTE_W-1:0] BYTE_READ_CTRL = BYTE_W'(3);
  localparam logic [BYTE_W-1:0] BYTE_RX_FIRST  = BYTE_W'(4);
  localparam logic [BYTE_W-1:0] BYTE_WR_END    = BYTE_W'(3 + BYTES_PER_TRANSFER);
  localparam logic [BYTE_W-1:0] BYTE_RD_END    = BYTE_W'(4 + BYTES_PER_TRANSFER);
  localparam logic [BIT_W-1:0]  BIT_ACK        = BIT_W'(8);

  // Configuration register indexes
  localparam logic [1:0] REG_CONTROL   = 2'd0;
  localparam logic [1:0] REG_HALF_PER  = 2'd1;
  localparam logic [1:0] REG_WR_WAIT   = 2'd2;
  localparam int unsigned CFG_DATA_W   = 24;

  // Reset values of the configuration registers
  localparam logic [7:0]        RST_CONTROL  = 8'd160;
  localparam logic [7:0]        RST_HALF_PER = 8'd2;
  localparam logic [TICK_W-1:0] RST_WR_WAIT  = 24'd50000;

  // Operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3,
    PH_BL, PH_BH, PH_BT, PH_SP0, PH_SP1, PH_SP2, PH_WAIT
  } phase_t;

  // Input word: one tick
  typedef struct packed {
    logic        command_valid;
    logic        operation;
    logic [15:0] mem_address;
    logic [31:0] write_data;
    logic        sda_in;
  } in_word_t;

  // Result word: pin levels and status after the tick
  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        write_protect;
    logic        busy_res;
    logic        done_res;
    logic        nack_error;
    logic [31:0] read_data;
  } out_word_t;

endpackage

`default_nettype wire

/* hdl/i2cew_in_if.sv */
// ----------------------------------------------------------------------------
// i2cew_in_if: input channel
// Valid/ready channel carrying one tick word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cew_in_if import i2cew_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/i2cew_out_if.sv */
// ----------------------------------------------------------------------------
// i2cew_out_if: result channel
// Valid/ready channel carrying one result word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cew_out_if import i2cew_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/i2c_eeprom_word_transfer.sv */
// ----------------------------------------------------------------------------
// i2c_eeprom_word_transfer: I2C master for 16-bit-addressed EEPROM transfers
// Bus sequencer stepped once per input word; one result word per input word.
// ----------------------------------------------------------------------------
// Every accepted input word is one bus tick: it may start a four-byte read or
// write (ignored while busy) and always carries the sampled SDA level. The
// sequencer advances by one tick per word and answers each word with exactly
// one result word holding SCL, SDA drive, write protect, busy, and, on the
// finishing tick, done with the NACK flag and the read data. One word is taken
// per clock: the whole tick update is a single pass of logic from the state
// registers into the result register, and a word's result is offered on
// out_ch in the clock after the word is taken. A new word is taken in the same
// clock that the previous result leaves, so words flow back to back; while a
// result waits for out_ch.ready, in_ch.ready stays low. Configuration writes
// are taken at any edge with cfg_we high and act at once.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_word_transfer import i2cew_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  i2cew_in_if.sink                   in_ch,
  i2cew_out_if.source                out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [7:0]        ctrl_r;
  logic [7:0]        half_r;
  logic [TICK_W-1:0] wwait_r;

  // Sequencer state
  phase_t            phase_r,   phase_nxt;
  logic [TICK_W-1:0] tick_r,    tick_nxt;
  logic [BIT_W-1:0]  bit_r,     bit_nxt;
  logic [BYTE_W-1:0] byte_r,    byte_nxt;
  logic [7:0]        shift_r,   shift_nxt;
  logic              op_r,      op_nxt;
  logic [15:0]       addr_r,    addr_nxt;
  logic [31:0]       data_r,    data_nxt;
  logic              err_r,     err_nxt;
  logic              scl_r,     scl_nxt;
  logic              sda_r,     sda_nxt;
  logic              prot_r,    prot_nxt;

  // Result register
  logic              out_valid_r;
  out_word_t         out_word_r, out_word_nxt;

  logic              accept;

  // SDA value of the current bit cell
  function automatic logic cell_sda(input logic op, input logic [BYTE_W-1:0] by,
                                    input logic [BIT_W-1:0] bi, input logic [7:0] sh);
    logic recv;
    logic [BYTE_W:0] by_next;
    recv    = (op == OP_READ) && (by >= BYTE_RX_FIRST);
    by_next = {1'b0, by} + {{BYTE_W{1'b0}}, 1'b1};
    if (bi < BIT_ACK) begin
      if (recv) cell_sda = 1'b1;
      else      cell_sda = sh[3'(7 - bi)];
    end else if (recv) begin
      cell_sda = (by_next < {1'b0, BYTE_RD_END}) ? 1'b0 : 1'b1;
    end else begin
      cell_sda = 1'b1;
    end
  endfunction

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_word_r;

  // One tick of the bus sequencer
  always_comb begin
    logic              recv;
    logic              adv;
    logic              do_load;
    logic              do_enter;
    logic              done;
    phase_t            ent_ph;
    logic [TICK_W-1:0] limit;

    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    shift_nxt = shift_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    data_nxt  = data_r;
    err_nxt   = err_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    prot_nxt  = prot_r;
    do_load   = 1'b0;
    do_enter  = 1'b0;
    done      = 1'b0;
    ent_ph    = PH_IDLE;
    adv       = 1'b0;
    limit     = '0;

    if (phase_r == PH_IDLE) begin
      // Latch a new command
      if (in_ch.payload.command_valid) begin
        op_nxt    = in_ch.payload.operation;
        addr_nxt  = in_ch.payload.mem_address;
        data_nxt  = (in_ch.payload.operation == OP_WRITE) ? in_ch.payload.write_data : '0;
        err_nxt   = 1'b0;
        byte_nxt  = '0;
        bit_nxt   = '0;
        shift_nxt = '0;
        prot_nxt  = (in_ch.payload.operation == OP_WRITE) ? 1'b0 : 1'b1;
        do_enter  = 1'b1;
        ent_ph    = PH_ST0;
      end
    end else begin
      // Slot timer
      tick_nxt = tick_r + TICK_W'(1);
      if (phase_r == PH_WAIT)  limit = wwait_r;
      else if (half_r == '0)   limit = TICK_W'(1);
      else                     limit = {{(TICK_W-8){1'b0}}, half_r};
      adv = (tick_nxt >= limit);
    end

    recv = (op_r == OP_READ) && (byte_r >= BYTE_RX_FIRST);

    if (adv) begin
      do_enter = 1'b1;
      unique case (phase_r)
        PH_ST0: ent_ph = PH_ST1;
        PH_ST1: ent_ph = PH_ST2;
        PH_ST2: ent_ph = PH_ST3;
        PH_ST3: begin
          do_load = 1'b1;
          ent_ph  = PH_BL;
        end
        PH_BL:  ent_ph = PH_BH;
        PH_BH: begin
          // Sample SDA at the end of the high slot
          if (bit_r < BIT_ACK) begin
            if (recv) shift_nxt = {shift_r[6:0], in_ch.payload.sda_in};
          end else if (!recv && in_ch.payload.sda_in) begin
            err_nxt = 1'b1;
          end
          ent_ph = PH_BT;
        end
        PH_BT: begin
          if (bit_r < BIT_ACK) begin
            bit_nxt = bit_r + BIT_W'(1);
            ent_ph  = PH_BL;
          end else begin
            // End of byte
            if (recv) data_nxt = {data_r[23:0], shift_r};
            byte_nxt = byte_r + BYTE_W'(1);
            if (op_r == OP_WRITE) begin
              if (byte_nxt < BYTE_WR_END) begin
                do_load = 1'b1;
                ent_ph  = PH_BL;
              end else begin
                ent_ph = PH_SP0;
              end
            end else if (byte_nxt == BYTE_READ_CTRL) begin
              ent_ph = PH_ST0;
            end else if (byte_nxt < BYTE_RD_END) begin
              do_load = 1'b1;
              ent_ph  = PH_BL;
            end else begin
              ent_ph = PH_SP0;
            end
          end
        end
        PH_SP0: ent_ph = PH_SP1;
        PH_SP1: ent_ph = PH_SP2;
        PH_SP2: begin
          if (op_r == OP_WRITE && wwait_r != '0) begin
            ent_ph = PH_WAIT;
          end else begin
            prot_nxt = 1'b1;
            done     = 1'b1;
            ent_ph   = PH_IDLE;
          end
        end
        PH_WAIT: begin
          prot_nxt = 1'b1;
          done     = 1'b1;
          ent_ph   = PH_IDLE;
        end
        default: ent_ph = PH_IDLE;
      endcase
    end

    // Load the next byte to shift out
    if (do_load) begin
      if (byte_nxt == BYTE_W'(0))      shift_nxt = ctrl_r & 8'hFE;
      else if (byte_nxt == BYTE_W'(1)) shift_nxt = addr_r[15:8];
      else if (byte_nxt == BYTE_W'(2)) shift_nxt = addr_r[7:0];
      else if (op_r == OP_READ) begin
        shift_nxt = (byte_nxt == BYTE_READ_CTRL) ? (ctrl_r | 8'h01) : 8'h00;
      end else begin
        shift_nxt = data_nxt[31:24];
        data_nxt  = {data_nxt[23:0], 8'h00};
      end
      bit_nxt = '0;
    end

    // Enter a phase: restart the timer and set the pin levels
    if (do_enter) begin
      phase_nxt = ent_ph;
      tick_nxt  = '0;
      unique case (ent_ph)
        PH_ST0: sda_nxt = 1'b1;
        PH_ST1: begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        PH_ST2: begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
        PH_ST3: begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
        PH_BL: begin
          scl_nxt = 1'b0;
          sda_nxt = cell_sda(op_nxt, byte_nxt, bit_nxt, shift_nxt);
        end
        PH_BH: begin
          scl_nxt = 1'b1;
          sda_nxt = cell_sda(op_nxt, byte_nxt, bit_nxt, shift_nxt);
        end
        PH_BT: begin
          scl_nxt = 1'b0;
          sda_nxt = cell_sda(op_nxt, byte_nxt, bit_nxt, shift_nxt);
        end
        PH_SP0: begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
        PH_SP1: begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
        default: begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
      endcase
    end

    // Result word
    out_word_nxt.scl_out       = scl_nxt;
    out_word_nxt.sda_out       = sda_nxt;
    out_word_nxt.write_protect = prot_nxt;
    out_word_nxt.busy_res      = (phase_nxt != PH_IDLE);
    out_word_nxt.done_res      = done;
    out_word_nxt.nack_error    = done & err_nxt;
    out_word_nxt.read_data     = (done && op_nxt == OP_READ) ? data_nxt : '0;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= RST_CONTROL;
      half_r  <= RST_HALF_PER;
      wwait_r <= RST_WR_WAIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONTROL:  ctrl_r  <= cfg_data[7:0];
        REG_HALF_PER: half_r  <= cfg_data[7:0];
        REG_WR_WAIT:  wwait_r <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state, updated once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      byte_r  <= '0;
      shift_r <= '0;
      op_r    <= 1'b0;
      addr_r  <= '0;
      data_r  <= '0;
      err_r   <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      prot_r  <= 1'b1;
    end else if (accept) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      shift_r <= shift_nxt;
      op_r    <= op_nxt;
      addr_r  <= addr_nxt;
      data_r  <= data_nxt;
      err_r   <= err_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      prot_r  <= prot_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

`default_nettype wire
